[design/vertex_key_hash_table_defines.svh]
// Assertion macros for the vertex key hash table checker.
// No dependencies; included by the checker file only.
`ifndef VERTEX_KEY_HASH_TABLE_DEFINES_SVH
`define VERTEX_KEY_HASH_TABLE_DEFINES_SVH

// same-edge implication, off while reset is high
`define VKHT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vkht check failed");

// next-edge implication, off while reset is high
`define VKHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vkht check failed");

// same-edge implication that also holds across reset
`define VKHT_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("vkht check failed");

`endif

[design/vkht_pkg.sv]
// Shared types and constants for the vertex key hash table.
// No dependencies.
`timescale 1ns / 1ps

package vkht_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int SLOT_W          = 10;
   localparam int WORD_W          = 32;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef struct packed {
      word_type nrm_idx;
      word_type pos_idx;
      word_type tex_idx;
   } key_type;

   typedef struct packed {
      func_type func;
      key_type  key;
      word_type new_value;
   } probe_req_type;

   typedef struct packed {
      slot_type slot;
      word_type stored_value;
      logic     found;
      logic     table_full;
   } probe_rsp_type;

   // one table entry as kept in the slot memory
   typedef struct packed {
      logic     used;
      key_type  key;
      word_type value;
   } entry_type;

endpackage

[design/vkht_if.sv]
// Request and response channel interfaces (valid/ready).
// Depends on vkht_pkg for field widths.
`timescale 1ns / 1ps

interface vkht_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   vkht_pkg::word_type   nrm_idx;
   vkht_pkg::word_type   pos_idx;
   vkht_pkg::word_type   tex_idx;
   vkht_pkg::word_type   new_value;

   modport source (output valid, func, nrm_idx, pos_idx, tex_idx,
                   new_value, input ready);
   modport sink   (input valid, func, nrm_idx, pos_idx, tex_idx,
                   new_value, output ready);
endinterface

interface vkht_rsp_if;
   logic                 valid;
   logic                 ready;
   vkht_pkg::slot_type   slot;
   vkht_pkg::word_type   stored_value;
   logic                 found;
   logic                 table_full;

   modport source (output valid, slot, stored_value, found, table_full, input ready);
   modport sink   (input valid, slot, stored_value, found, table_full, output ready);
endinterface

[design/vkht_hash.sv]
// Home slot hash unit: 64-bit mix built on one shared 32x32 multiplier,
// then reduction modulo the table depth by reciprocal multiply. Uses vkht_pkg.
`timescale 1ns / 1ps

module vkht_hash #(
   parameter int TABLE_DEPTH = vkht_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  vkht_pkg::key_type    key,
   output logic                 done,
   output logic [IDX_W-1:0]     home
);

   localparam logic [31:0] C_NORMAL   = 32'd1610612741;
   localparam logic [31:0] C_POSITION = 32'd805306457;
   localparam logic [31:0] C_TEXTURE  = 32'd402653189;
   localparam logic [63:0] K_FIN1     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] K_FIN2     = 64'h94d049bb133111eb;
   localparam int          SHIFT1     = 30;
   localparam int          SHIFT2     = 27;
   localparam int          SHIFT3     = 31;
   localparam int          REM_W      = IDX_W + 1;
   localparam logic [31:0] DEPTH_C    = 32'(TABLE_DEPTH);
   // floor(2^32 / depth): quotient estimate is short by at most one
   localparam logic [31:0] RECIP      = 32'((64'd1 << 32) / TABLE_DEPTH);
   localparam logic [REM_W-1:0] DEPTH_R = REM_W'(TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE, S_MUL_N, S_MUL_P, S_MUL_T, S_MIX1,
      S_K1_LL, S_K1_LH, S_K1_HL, S_MIX2,
      S_K2_LL, S_K2_LH, S_K2_HL, S_K2_ACC,
      S_FOLD, S_QMUL, S_SUB, S_WRAP
   } step_type;

   step_type            step_ff;
   vkht_pkg::key_type   key_ff;
   logic [63:0]         x_ff;
   logic [63:0]         acc_ff;
   logic [63:0]         prod_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [IDX_W-1:0]    home_ff;
   logic                done_ff;

   logic [31:0]         mul_a;
   logic [31:0]         mul_b;
   logic [63:0]         mul_p;
   logic [63:0]         acc_hi_sum;
   logic [31:0]         fold;

   function automatic logic [63:0] xsh(input logic [63:0] v, input int sh);
      return v ^ (v >> sh);
   endfunction

   // upper cross products only land in the top word
   assign acc_hi_sum = acc_ff + {prod_ff[31:0], 32'd0};
   assign fold       = acc_ff[31:0] ^ acc_ff[SHIFT3 +: 32];

   always_comb begin
      mul_a = x_ff[31:0];
      mul_b = K_FIN1[31:0];
      case (step_ff)
         S_MUL_N: begin mul_a = key_ff.nrm_idx; mul_b = C_NORMAL;   end
         S_MUL_P: begin mul_a = key_ff.pos_idx; mul_b = C_POSITION; end
         S_MUL_T: begin mul_a = key_ff.tex_idx; mul_b = C_TEXTURE;  end
         S_K1_LL: begin mul_a = x_ff[31:0];  mul_b = K_FIN1[31:0];  end
         S_K1_LH: begin mul_a = x_ff[31:0];  mul_b = K_FIN1[63:32]; end
         S_K1_HL: begin mul_a = x_ff[63:32]; mul_b = K_FIN1[31:0];  end
         S_K2_LL: begin mul_a = x_ff[31:0];  mul_b = K_FIN2[31:0];  end
         S_K2_LH: begin mul_a = x_ff[31:0];  mul_b = K_FIN2[63:32]; end
         S_K2_HL: begin mul_a = x_ff[63:32]; mul_b = K_FIN2[31:0];  end
         S_FOLD:  begin mul_a = fold;           mul_b = RECIP;   end
         S_QMUL:  begin mul_a = prod_ff[63:32]; mul_b = DEPTH_C; end
         default: begin mul_a = x_ff[31:0];     mul_b = K_FIN1[31:0]; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         prod_ff <= mul_p;
         case (step_ff)
            S_IDLE: begin
               if (start) begin
                  key_ff  <= key;
                  step_ff <= S_MUL_N;
               end
            end
            S_MUL_N:  step_ff <= S_MUL_P;
            S_MUL_P: begin
               acc_ff  <= prod_ff;
               step_ff <= S_MUL_T;
            end
            S_MUL_T: begin
               acc_ff  <= acc_ff + prod_ff;
               step_ff <= S_MIX1;
            end
            S_MIX1: begin
               x_ff    <= xsh(acc_ff + prod_ff, SHIFT1);
               step_ff <= S_K1_LL;
            end
            S_K1_LL:  step_ff <= S_K1_LH;
            S_K1_LH: begin
               acc_ff  <= prod_ff;
               step_ff <= S_K1_HL;
            end
            S_K1_HL: begin
               acc_ff  <= acc_hi_sum;
               step_ff <= S_MIX2;
            end
            S_MIX2: begin
               x_ff    <= xsh(acc_hi_sum, SHIFT2);
               step_ff <= S_K2_LL;
            end
            S_K2_LL:  step_ff <= S_K2_LH;
            S_K2_LH: begin
               acc_ff  <= prod_ff;
               step_ff <= S_K2_HL;
            end
            S_K2_HL: begin
               acc_ff  <= acc_hi_sum;
               step_ff <= S_K2_ACC;
            end
            S_K2_ACC: begin
               acc_ff  <= acc_hi_sum;
               step_ff <= S_FOLD;
            end
            S_FOLD: begin
               x_ff    <= {32'd0, fold};
               step_ff <= S_QMUL;
            end
            S_QMUL:   step_ff <= S_SUB;
            S_SUB: begin
               // true remainder plus at most one depth
               rem_ff  <= REM_W'(x_ff[31:0] - prod_ff[31:0]);
               step_ff <= S_WRAP;
            end
            S_WRAP: begin
               if (rem_ff >= DEPTH_R) begin
                  home_ff <= IDX_W'(rem_ff - DEPTH_R);
               end else begin
                  home_ff <= IDX_W'(rem_ff);
               end
               done_ff <= 1'b1;
               step_ff <= S_IDLE;
            end
            default: step_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

[design/vkht_probe.sv]
// Slot memory with linear probe sequencer and post-reset clearing pass.
// Uses vkht_pkg types.
`timescale 1ns / 1ps

module vkht_probe #(
   parameter int TABLE_DEPTH = vkht_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    table_ready,
   input  logic                    start,
   input  vkht_pkg::probe_req_type preq,
   input  logic [IDX_W-1:0]        home,
   output logic                    res_valid,
   input  logic                    res_ready,
   output vkht_pkg::probe_rsp_type res
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      P_CLEAR, P_IDLE, P_CHECK, P_DONE
   } pstate_type;

   pstate_type                 state_ff;
   logic [IDX_W-1:0]           clr_ff;
   logic [IDX_W-1:0]           cur_ff;
   logic [IDX_W-1:0]           home_ff;
   logic [IDX_W-1:0]           cnt_ff;
   vkht_pkg::probe_req_type    item_ff;
   vkht_pkg::probe_rsp_type    res_ff;

   vkht_pkg::entry_type        mem [TABLE_DEPTH];
   vkht_pkg::entry_type        mem_q_ff;

   logic [IDX_W-1:0]           nxt;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           wr_addr;
   logic                       wr_en;
   vkht_pkg::entry_type        wr_data;
   logic                       is_empty;
   logic                       is_match;
   logic                       is_insert;

   assign nxt       = (cur_ff == LAST) ? '0 : cur_ff + 1'b1;
   assign is_empty  = !mem_q_ff.used;
   assign is_match  = mem_q_ff.used && (mem_q_ff.key == item_ff.key);
   assign is_insert = (item_ff.func == vkht_pkg::FUNC_INSERT);

   // read ahead one slot while the current one is checked
   always_comb begin
      case (state_ff)
         P_IDLE:  rd_addr = home;
         P_CHECK: rd_addr = nxt;
         default: rd_addr = cur_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = '{used: 1'b1, key: item_ff.key, value: item_ff.new_value};
      case (state_ff)
         P_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         P_CHECK: wr_en = is_empty && is_insert;
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_CLEAR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            P_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST) begin
                  state_ff <= P_IDLE;
               end
            end
            P_IDLE: begin
               if (start) begin
                  item_ff  <= preq;
                  cur_ff   <= home;
                  home_ff  <= home;
                  cnt_ff   <= '0;
                  state_ff <= P_CHECK;
               end
            end
            P_CHECK: begin
               if (is_empty) begin
                  res_ff.slot         <= vkht_pkg::slot_type'(cur_ff);
                  res_ff.stored_value <= is_insert ? item_ff.new_value : '0;
                  res_ff.found        <= 1'b0;
                  res_ff.table_full   <= 1'b0;
                  state_ff            <= P_DONE;
               end else if (is_match) begin
                  res_ff.slot         <= vkht_pkg::slot_type'(cur_ff);
                  res_ff.stored_value <= mem_q_ff.value;
                  res_ff.found        <= 1'b1;
                  res_ff.table_full   <= 1'b0;
                  state_ff            <= P_DONE;
               end else if (cnt_ff == LAST) begin
                  // wrapped all the way round: key absent, no free slot
                  res_ff.slot         <= vkht_pkg::slot_type'(home_ff);
                  res_ff.stored_value <= '0;
                  res_ff.found        <= 1'b0;
                  res_ff.table_full   <= 1'b1;
                  state_ff            <= P_DONE;
               end else begin
                  cur_ff <= nxt;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            P_DONE: begin
               if (res_ready) begin
                  state_ff <= P_IDLE;
               end
            end
            default: state_ff <= P_CLEAR;
         endcase
      end
   end

   assign table_ready = (state_ff != P_CLEAR);
   assign res_valid   = (state_ff == P_DONE);
   assign res         = res_ff;

endmodule

[design/vertex_key_hash_table.sv]
// Vertex key hash table: open addressing, linear probing, keys of three
// 32-bit vertex indices.
//
// req_if (sink): one transaction per insert-or-find (func = 0) or lookup
// (func = 1) with the three key indices and the value to store on insert.
// rsp_if (source): exactly one transaction per request, in order, carrying
// the slot, the value held there, a found flag and a table-full flag.
//
// A request is first hashed to its home slot on one shared 32x32
// multiplier (weighted sum, two 64-bit finalizer products, modulo by
// reciprocal); probing then checks one slot per cycle on the single read
// port of the slot memory. One item is in work at a time; the next request
// is taken the cycle after a result is handed to the output register.
//
// Reset: synchronous. After reset the slot memory is swept once to mark
// every slot empty, with req_if.ready held low.
// A stalled rsp_if keeps its result in the output register; one further
// request may still be accepted and hashed/probed behind it.
`timescale 1ns / 1ps

module vertex_key_hash_table #(
   parameter int TABLE_DEPTH = vkht_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vkht_req_if.sink    req_if,
   vkht_rsp_if.source  rsp_if
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic                      busy_ff;
   vkht_pkg::probe_req_type   item_ff;
   logic                      rsp_valid_ff;
   vkht_pkg::probe_rsp_type   rsp_data_ff;

   logic                      req_accept;
   logic                      table_ready;
   logic                      hash_done;
   logic [IDX_W-1:0]          home;
   logic                      res_valid;
   logic                      res_ready;
   logic                      res_move;
   vkht_pkg::probe_rsp_type   res;
   vkht_pkg::key_type         req_key;

   assign req_key.nrm_idx = req_if.nrm_idx;
   assign req_key.pos_idx = req_if.pos_idx;
   assign req_key.tex_idx = req_if.tex_idx;

   assign req_if.ready = !busy_ff && table_ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign res_ready    = !rsp_valid_ff || rsp_if.ready;
   assign res_move     = res_valid && res_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            busy_ff       <= 1'b1;
            item_ff.func  <= vkht_pkg::func_type'(req_if.func);
            item_ff.key   <= req_key;
            item_ff.new_value <= req_if.new_value;
         end else if (res_move) begin
            busy_ff <= 1'b0;
         end

         if (res_move) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   vkht_hash #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .key   (req_key),
      .done  (hash_done),
      .home  (home)
   );

   vkht_probe #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_probe (
      .clock       (clock),
      .reset       (reset),
      .table_ready (table_ready),
      .start       (hash_done),
      .preq        (item_ff),
      .home        (home),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.slot         = rsp_data_ff.slot;
   assign rsp_if.stored_value = rsp_data_ff.stored_value;
   assign rsp_if.found        = rsp_data_ff.found;
   assign rsp_if.table_full   = rsp_data_ff.table_full;

endmodule

[design/vkht_checker.sv]
// Port-level checker for the vertex key hash table, bound to the top level.
// Depends on vkht_pkg and vertex_key_hash_table_defines.svh.
`timescale 1ns / 1ps
`include "vertex_key_hash_table_defines.svh"

module vkht_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input vkht_pkg::slot_type  rsp_slot,
   input vkht_pkg::word_type  rsp_stored_value,
   input logic                rsp_found,
   input logic                rsp_table_full
);

   // requests taken but not yet answered
   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + {1'b0, req_fire} - {1'b0, rsp_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `VKHT_ASSERT_ALWAYS(a_ready_low_after_reset, clock, $past(reset), !req_ready)
   `VKHT_ASSERT_NEXT(a_rsp_held_on_stall, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot) && $stable(rsp_stored_value) && $stable(rsp_found) && $stable(rsp_table_full))
   `VKHT_ASSERT_IMPLY(a_full_excludes_hit, clock, reset, rsp_valid && rsp_table_full, !rsp_found && (rsp_stored_value == '0))
   `VKHT_ASSERT_IMPLY(a_rsp_has_request, clock, reset, rsp_fire, (pend_ff != 2'd0) && (pend_ff != 2'd3))

endmodule

bind vertex_key_hash_table vkht_checker u_vkht_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_slot         (rsp_if.slot),
   .rsp_stored_value (rsp_if.stored_value),
   .rsp_found        (rsp_if.found),
   .rsp_table_full   (rsp_if.table_full)
);

[dv/tb_top.sv]
// Testbench for vertex_key_hash_table: directed rows, then random insert/lookup traffic
// that fills the table to full. Expected responses come from a behavioral table model.
// Depends on vkht_pkg, vkht_if.sv and the vertex_key_hash_table RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned DEPTH       = vkht_pkg::TABLE_DEPTH_DEF;
   localparam int unsigned CYCLE_LIMIT = 5_000_000;

   typedef struct {
      vkht_pkg::probe_req_type req;
      bit                      typed;
      vkht_pkg::probe_rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   vkht_req_if req_ch ();
   vkht_rsp_if rsp_ch ();

   vertex_key_hash_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // table model state
   bit                 slot_used [DEPTH];
   vkht_pkg::key_type  slot_key  [DEPTH];
   vkht_pkg::word_type slot_value[DEPTH];
   int unsigned        fill_count;
   vkht_pkg::key_type  stored_keys[$];

   vkht_pkg::probe_rsp_type expected_rsp[$];
   vkht_pkg::probe_rsp_type oldest;
   stim_row_type            directed_rows[$];
   int unsigned             error_count = 0;
   int unsigned             cycle_count = 0;
   int unsigned             send_idle_pct;
   int unsigned             recv_idle_pct;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned home_slot(vkht_pkg::key_type k);
      logic [63:0] h;
      h = 64'(k.nrm_idx) * 64'd1610612741 + 64'(k.pos_idx) * 64'd805306457
        + 64'(k.tex_idx) * 64'd402653189;
      h = (h ^ (h >> 30)) * 64'hbf58476d1ce4e5b9;
      h = (h ^ (h >> 27)) * 64'h94d049bb133111eb;
      h = h ^ (h >> 31);
      return h[31:0] % DEPTH;
   endfunction

   // linear probe from the home slot; inserts update the model
   function automatic vkht_pkg::probe_rsp_type probe_table(vkht_pkg::probe_req_type r);
      vkht_pkg::probe_rsp_type rsp;
      int unsigned             s;
      bit                      done;
      s = home_slot(r.key);
      rsp.slot         = vkht_pkg::slot_type'(s);
      rsp.stored_value = '0;
      rsp.found        = 1'b0;
      rsp.table_full   = 1'b1;
      done = 1'b0;
      for (int unsigned k = 0; k < DEPTH && !done; k++) begin
         if (!slot_used[s]) begin
            rsp.table_full = 1'b0;
            rsp.slot       = vkht_pkg::slot_type'(s);
            if (r.func == vkht_pkg::FUNC_INSERT) begin
               slot_used[s]     = 1'b1;
               slot_key[s]      = r.key;
               slot_value[s]    = r.new_value;
               rsp.stored_value = r.new_value;
               fill_count++;
               stored_keys.push_back(r.key);
            end
            done = 1'b1;
         end else if (slot_key[s] == r.key) begin
            rsp.table_full   = 1'b0;
            rsp.found        = 1'b1;
            rsp.slot         = vkht_pkg::slot_type'(s);
            rsp.stored_value = slot_value[s];
            done = 1'b1;
         end else begin
            s = (s + 1) % DEPTH;
         end
      end
      return rsp;
   endfunction

   function automatic void add_row(vkht_pkg::func_type f, vkht_pkg::word_type n,
                                   vkht_pkg::word_type p, vkht_pkg::word_type t,
                                   vkht_pkg::word_type v, bit typed,
                                   vkht_pkg::word_type ev, bit ef, bit efull);
      stim_row_type row;
      row.req.func          = f;
      row.req.key.nrm_idx   = n;
      row.req.key.pos_idx   = p;
      row.req.key.tex_idx   = t;
      row.req.new_value     = v;
      row.typed             = typed;
      row.rsp.slot          = '0;
      row.rsp.stored_value  = ev;
      row.rsp.found         = ef;
      row.rsp.table_full    = efull;
      directed_rows.push_back(row);
   endfunction

   // small values make repeated and near-equal keys likely
   function automatic vkht_pkg::word_type rand_index();
      return ($urandom_range(3) == 0) ? vkht_pkg::word_type'($urandom_range(3))
                                      : vkht_pkg::word_type'($urandom);
   endfunction

   function automatic vkht_pkg::probe_req_type random_req(int unsigned fresh_pct);
      vkht_pkg::probe_req_type r;
      int unsigned             sel;
      case ($urandom_range(7))
         0:       r.new_value = '0;
         1:       r.new_value = '1;
         default: r.new_value = $urandom;
      endcase
      r.key  = {rand_index(), rand_index(), rand_index()};
      r.func = vkht_pkg::FUNC_INSERT;
      if ($urandom_range(99) >= fresh_pct && stored_keys.size() != 0) begin
         sel = $urandom_range(2);
         if (sel != 2)
            r.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
         r.func = (sel == 0) ? vkht_pkg::FUNC_INSERT : vkht_pkg::FUNC_LOOKUP;
      end
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_req(input vkht_pkg::probe_req_type r, input bit typed,
                           input vkht_pkg::probe_rsp_type typed_rsp);
      vkht_pkg::probe_rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.func      = r.func;
      req_ch.nrm_idx   = r.key.nrm_idx;
      req_ch.pos_idx   = r.key.pos_idx;
      req_ch.tex_idx   = r.key.tex_idx;
      req_ch.new_value = r.new_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = probe_table(r);
      if (typed) begin
         pred.stored_value = typed_rsp.stored_value;
         pred.found        = typed_rsp.found;
         pred.table_full   = typed_rsp.table_full;
      end
      expected_rsp.push_back(pred);
      @(negedge clock);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with nothing outstanding: slot %0d", rsp_ch.slot);
            error_count++;
         end else begin
            oldest = expected_rsp.pop_front();
            if (rsp_ch.slot !== oldest.slot) begin
               $error("slot: expected %0d, got %0d", oldest.slot, rsp_ch.slot);
               error_count++;
            end
            if (rsp_ch.stored_value !== oldest.stored_value) begin
               $error("stored_value: expected %h, got %h", oldest.stored_value,
                      rsp_ch.stored_value);
               error_count++;
            end
            if (rsp_ch.found !== oldest.found) begin
               $error("found: expected %b, got %b", oldest.found, rsp_ch.found);
               error_count++;
            end
            if (rsp_ch.table_full !== oldest.table_full) begin
               $error("table_full: expected %b, got %b", oldest.table_full,
                      rsp_ch.table_full);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vertex_key_hash_table test failed");
         $finish;
      end
   end

   initial begin
      int unsigned home0;
      int unsigned c1, c2, w1, w2;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.func      = 1'b0;
      req_ch.nrm_idx   = '0;
      req_ch.pos_idx   = '0;
      req_ch.tex_idx   = '0;
      req_ch.new_value = '0;
      fill_count    = 0;
      send_idle_pct = 14;
      recv_idle_pct = 72;

      // keys sharing the home slot of the zero key, and keys homed on the last slot
      home0 = home_slot('0);
      c1 = 0;
      c2 = 0;
      for (int unsigned i = 1; c2 == 0; i++)
         if (home_slot({vkht_pkg::word_type'(i), vkht_pkg::word_type'(0),
                        vkht_pkg::word_type'(0)}) == home0) begin
            if (c1 == 0) c1 = i;
            else c2 = i;
         end
      w1 = 0;
      w2 = 0;
      for (int unsigned i = 1; w2 == 0; i++)
         if (home_slot({vkht_pkg::word_type'(0), vkht_pkg::word_type'(i),
                        vkht_pkg::word_type'(0)}) == DEPTH - 1) begin
            if (w1 == 0) w1 = i;
            else w2 = i;
         end

      add_row(vkht_pkg::FUNC_LOOKUP, '0, '0, '0, '0,           1'b1, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '0, '0, '0, '1,           1'b1, '1, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '0, '0, '0, 32'h12345678, 1'b1, '1, 1'b1, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, '0, '0, '0, 32'hdeadbeef, 1'b1, '1, 1'b1, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '1, '1, '1, '0,           1'b1, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, '1, '1, '1, '0,           1'b1, '0, 1'b1, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, '1, '0, '0, '1,           1'b1, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '1, '0, '0, 32'h1,        1'b1, 32'h1, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '0, '1, '0, 32'h80000000,
              1'b1, 32'h80000000, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '0, '0, '1, 32'h7fffffff,
              1'b1, 32'h7fffffff, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, '0, '1, '0, '0,
              1'b1, 32'h80000000, 1'b1, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, 32'd1, 32'd2, 32'd3, '0,  1'b1, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, 32'd1, 32'd2, 32'd3, 32'ha5a5a5a5,
              1'b1, 32'ha5a5a5a5, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, 32'd3, 32'd2, 32'd1, '0,  1'b1, '0, 1'b0, 1'b0);
      // collisions on the zero key's home slot
      add_row(vkht_pkg::FUNC_INSERT, c1, '0, '0, 32'h11,       1'b0, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, c2, '0, '0, 32'h22,       1'b0, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, c2, '0, '0, '0,           1'b0, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, c1, '0, '0, 32'h99,       1'b0, '0, 1'b0, 1'b0);
      // probe wrapping from the last slot to slot zero
      add_row(vkht_pkg::FUNC_INSERT, '0, w1, '0, 32'h33,       1'b0, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_INSERT, '0, w2, '0, 32'h44,       1'b0, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, '0, w2, '0, '0,           1'b0, '0, 1'b0, 1'b0);
      add_row(vkht_pkg::FUNC_LOOKUP, '0, w1, '0, '0,           1'b0, '0, 1'b0, 1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      repeat (60) send_req(random_req(50), 1'b0, '0);

      // fill the table, mostly with new keys
      send_idle_pct = 72;
      recv_idle_pct = 14;
      while (fill_count < DEPTH) send_req(random_req(95), 1'b0, '0);

      // full table: absent keys report full, present keys still hit
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (40) send_req(random_req(40), 1'b0, '0);
      req_ch.valid = 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("vertex_key_hash_table test passed");
      else
         $display("vertex_key_hash_table test failed");
      $finish;
   end

endmodule
